>>> hdl/consistent_hash_ring_lookup_assert.svh
// assertion macros for the hash ring lookup
// no dependencies; included by the top level
`ifndef CONSISTENT_HASH_RING_LOOKUP_ASSERT_SVH
`define CONSISTENT_HASH_RING_LOOKUP_ASSERT_SVH

// same-cycle implication
`define CHRL_ASSERT_IMP(name, clk, rstn, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("chrl assertion failed");

// next-cycle implication
`define CHRL_ASSERT_NXT(name, clk, rstn, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("chrl assertion failed");

`endif

>>> hdl/chrl_pkg.sv
// shared types and constants for the hash ring lookup
// no dependencies
package chrl_pkg;

    localparam int unsigned MAX_POINTS_DEF = 1024;
    localparam int unsigned POS_W          = 32;
    localparam int unsigned SRV_W          = 4;
    localparam int unsigned MODE_W         = 2;
    localparam int unsigned STATUS_W       = 2;

    localparam logic [MODE_W-1:0] MODE_INSERT = 2'd0;
    localparam logic [MODE_W-1:0] MODE_LOOKUP = 2'd1;
    localparam logic [MODE_W-1:0] MODE_CLEAR  = 2'd2;

    localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
    localparam logic [STATUS_W-1:0] ST_DUP   = 2'd1;
    localparam logic [STATUS_W-1:0] ST_FULL  = 2'd2;
    localparam logic [STATUS_W-1:0] ST_EMPTY = 2'd3;

    typedef struct packed {
        logic             valid;
        logic [POS_W-1:0] position;
        logic [SRV_W-1:0] server;
    } chrl_point_t;

    typedef struct packed {
        logic insert;
        logic clear;
    } chrl_cmd_t;

    typedef struct packed {
        logic             ge;
        logic             eq;
        logic [SRV_W-1:0] server;
    } chrl_leaf_t;

endpackage

>>> hdl/chrl_cell.sv
// one ring cell: holds a point, compares it with the key, shifts on insert
// depends on chrl_pkg
module chrl_cell (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic [chrl_pkg::POS_W-1:0] key,
    input  logic [chrl_pkg::SRV_W-1:0] new_server,
    input  chrl_pkg::chrl_cmd_t        cmd,
    input  chrl_pkg::chrl_point_t      left_point,
    input  logic                       left_ge,
    output chrl_pkg::chrl_point_t      point,
    output logic                       ge,
    output chrl_pkg::chrl_leaf_t       leaf
);

    logic                       valid_reg;
    logic [chrl_pkg::POS_W-1:0] position_reg;
    logic [chrl_pkg::SRV_W-1:0] server_reg;
    logic                       hit;
    logic                       take_new;

    assign ge       = valid_reg && (position_reg >= key);
    assign hit      = ge && !left_ge;
    assign take_new = ge || (!valid_reg && left_point.valid);

    assign point.valid    = valid_reg;
    assign point.position = position_reg;
    assign point.server   = server_reg;

    assign leaf.ge     = ge;
    assign leaf.eq     = valid_reg && (position_reg == key);
    assign leaf.server = hit ? server_reg : '0;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (cmd.clear) begin
            valid_reg <= 1'b0;
        end else if (cmd.insert && (left_ge || take_new)) begin
            valid_reg <= 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.insert) begin
            if (left_ge) begin
                position_reg <= left_point.position;
                server_reg   <= left_point.server;
            end else if (take_new) begin
                position_reg <= key;
                server_reg   <= new_server;
            end
        end
    end

endmodule

>>> hdl/chrl_or_tree.sv
// registered or-tree gathering the per-cell compare words
// depends on chrl_pkg
module chrl_or_tree #(
    parameter int unsigned N = chrl_pkg::MAX_POINTS_DEF
) (
    input  logic                 aclk,
    input  chrl_pkg::chrl_leaf_t leaf [N],
    output chrl_pkg::chrl_leaf_t root
);

    localparam int unsigned NP = 1 << $clog2(N);

    chrl_pkg::chrl_leaf_t node_reg [1:2*NP-1];

    for (genvar j = 0; j < NP; j++) begin : g_leaf
        if (j < N) begin : g_used
            always_ff @(posedge aclk) begin
                node_reg[NP+j] <= leaf[j];
            end
        end else begin : g_pad
            always_ff @(posedge aclk) begin
                node_reg[NP+j] <= '0;
            end
        end
    end

    for (genvar k = 1; k < NP; k++) begin : g_node
        always_ff @(posedge aclk) begin
            node_reg[k] <= chrl_pkg::chrl_leaf_t'(node_reg[2*k] | node_reg[2*k+1]);
        end
    end

    assign root = node_reg[1];

endmodule

>>> hdl/consistent_hash_ring_lookup.sv
// Consistent hash ring lookup. The ring is a row of MAX_POINTS cells kept in ascending
// position order, valid cells packed from cell 0. Every cell compares its point with the
// word's key at once; a registered or-tree of depth clog2(MAX_POINTS) gathers the hit,
// duplicate and above-key flags. An insert shifts the cells at and above its place one
// cell up; a clear drops all valid bits. Each word waits in SEARCH for the depth of the
// or-tree, then in FINISH until the output is free, and its result is registered; one
// word is in work at a time, so a new word is taken only after the last one has left
// FINISH, and s_ready rises again while the last result still waits on m_ready.
// depends on chrl_pkg, chrl_cell, chrl_or_tree, consistent_hash_ring_lookup_assert.svh
`include "consistent_hash_ring_lookup_assert.svh"
module consistent_hash_ring_lookup #(
    parameter int unsigned MAX_POINTS = chrl_pkg::MAX_POINTS_DEF
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_valid,
    output logic                          s_ready,
    input  logic [chrl_pkg::MODE_W-1:0]   s_mode,
    input  logic [chrl_pkg::POS_W-1:0]    s_ring_position,
    input  logic [chrl_pkg::SRV_W-1:0]    s_server_index,
    output logic                          m_valid,
    input  logic                          m_ready,
    output logic [chrl_pkg::SRV_W-1:0]    m_found_server,
    output logic [chrl_pkg::STATUS_W-1:0] m_status
);

    localparam int unsigned LEVELS = $clog2(MAX_POINTS);
    localparam int unsigned CNT_W  = $clog2(LEVELS + 1);
    localparam int unsigned LAST   = MAX_POINTS - 1;

    typedef enum logic [1:0] {
        IDLE,
        SEARCH,
        FINISH
    } state_t;

    state_t                        state_reg;
    logic [CNT_W-1:0]              cnt_reg;
    logic [chrl_pkg::MODE_W-1:0]   mode_reg;
    logic [chrl_pkg::POS_W-1:0]    key_reg;
    logic [chrl_pkg::SRV_W-1:0]    server_reg;
    logic                          m_valid_reg;
    logic [chrl_pkg::SRV_W-1:0]    found_reg;
    logic [chrl_pkg::STATUS_W-1:0] status_reg;

    chrl_pkg::chrl_point_t point_w [MAX_POINTS];
    logic                  ge_w    [MAX_POINTS];
    chrl_pkg::chrl_leaf_t  leaf_w  [MAX_POINTS];
    logic [MAX_POINTS-1:0] valid_vec;
    chrl_pkg::chrl_leaf_t  root;
    chrl_pkg::chrl_cmd_t   cmd;

    logic                          out_free;
    logic                          ring_full;
    logic                          ring_empty;
    logic [chrl_pkg::SRV_W-1:0]    res_found;
    logic [chrl_pkg::STATUS_W-1:0] res_status;

    chrl_pkg::chrl_point_t head_left;
    assign head_left.valid    = 1'b1;
    assign head_left.position = '0;
    assign head_left.server   = '0;

    for (genvar i = 0; i < MAX_POINTS; i++) begin : g_cell
        if (i == 0) begin : g_head
            chrl_cell u_cell (
                .aclk       (aclk),
                .aresetn    (aresetn),
                .key        (key_reg),
                .new_server (server_reg),
                .cmd        (cmd),
                .left_point (head_left),
                .left_ge    (1'b0),
                .point      (point_w[i]),
                .ge         (ge_w[i]),
                .leaf       (leaf_w[i])
            );
        end else begin : g_body
            chrl_cell u_cell (
                .aclk       (aclk),
                .aresetn    (aresetn),
                .key        (key_reg),
                .new_server (server_reg),
                .cmd        (cmd),
                .left_point (point_w[i-1]),
                .left_ge    (ge_w[i-1]),
                .point      (point_w[i]),
                .ge         (ge_w[i]),
                .leaf       (leaf_w[i])
            );
        end
        assign valid_vec[i] = point_w[i].valid;
    end

    chrl_or_tree #(
        .N (MAX_POINTS)
    ) u_tree (
        .aclk (aclk),
        .leaf (leaf_w),
        .root (root)
    );

    assign out_free   = !m_valid_reg || m_ready;
    assign ring_full  = valid_vec[LAST];
    assign ring_empty = !valid_vec[0];

    always_comb begin
        res_found  = '0;
        res_status = chrl_pkg::ST_OK;
        case (mode_reg)
            chrl_pkg::MODE_INSERT: begin
                if (root.eq) begin
                    res_status = chrl_pkg::ST_DUP;
                end else if (ring_full) begin
                    res_status = chrl_pkg::ST_FULL;
                end
            end
            chrl_pkg::MODE_LOOKUP: begin
                if (ring_empty) begin
                    res_status = chrl_pkg::ST_EMPTY;
                end else begin
                    res_found = root.ge ? root.server : point_w[0].server;
                end
            end
            chrl_pkg::MODE_CLEAR: begin
                res_status = chrl_pkg::ST_OK;
            end
            default: begin
                res_status = chrl_pkg::ST_OK;
            end
        endcase
    end

    assign cmd.insert = (state_reg == FINISH) && out_free &&
                        (mode_reg == chrl_pkg::MODE_INSERT) && !root.eq && !ring_full;
    assign cmd.clear  = (state_reg == FINISH) && out_free &&
                        (mode_reg == chrl_pkg::MODE_CLEAR);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= IDLE;
            cnt_reg     <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            if (m_valid_reg && m_ready) begin
                m_valid_reg <= 1'b0;
            end
            case (state_reg)
                IDLE: begin
                    if (s_valid) begin
                        mode_reg   <= s_mode;
                        key_reg    <= s_ring_position;
                        server_reg <= s_server_index;
                        cnt_reg    <= CNT_W'(LEVELS);
                        state_reg  <= SEARCH;
                    end
                end
                SEARCH: begin
                    if (cnt_reg == '0) begin
                        state_reg <= FINISH;
                    end else begin
                        cnt_reg <= cnt_reg - 1'b1;
                    end
                end
                FINISH: begin
                    if (out_free) begin
                        found_reg   <= res_found;
                        status_reg  <= res_status;
                        m_valid_reg <= 1'b1;
                        state_reg   <= IDLE;
                    end
                end
                default: begin
                    state_reg <= IDLE;
                end
            endcase
        end
    end

    assign s_ready        = (state_reg == IDLE);
    assign m_valid        = m_valid_reg;
    assign m_found_server = found_reg;
    assign m_status       = status_reg;

    `CHRL_ASSERT_NXT(a_ring_stable, aclk, aresetn, state_reg != FINISH, $stable(valid_vec))
    `CHRL_ASSERT_IMP(a_ring_packed, aclk, aresetn, 1'b1, (valid_vec & (valid_vec + 1'b1)) == '0)
    `CHRL_ASSERT_IMP(a_no_insert_full, aclk, aresetn, cmd.insert, !valid_vec[LAST])
    `CHRL_ASSERT_IMP(a_result_from_finish, aclk, aresetn, $rose(m_valid_reg), $past(state_reg == FINISH))

endmodule
